/* rtl/isl_pkg.sv */
// ----------------------------------------------------------------------------
// isl_pkg: shared definitions for the indexed shift list
// Operation and status codes, fixed port widths and the control bundle
// that the top level broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package isl_pkg;

    // Fixed widths of the channel fields.
    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Widest cell index over the supported capacity range (up to 1024).
    localparam int MAX_IDX_W = 10;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_WORD_BITS = 32;

    // Operation codes on the kind field.
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GET    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PUT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SHIFT  = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // Per-cell actions.
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_LOAD = 2'd1;  // target cell takes the new word
    localparam logic [1:0] CELL_INS  = 2'd2;  // target loads, cells above take left
    localparam logic [1:0] CELL_DEL  = 2'd3;  // target and cells above take right

    typedef struct packed {
        logic [1:0]           op;
        logic [MAX_IDX_W-1:0] target;
    } t_cell_ctl;

endpackage

/* rtl/indexed_shift_list_top.sv */
// ----------------------------------------------------------------------------
// indexed_shift_list_top: bounded ordered list of data words
// Append, get, put, insert, remove, pop and shift on a list held in a row
// of register cells that shift the whole tail in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid / o_ready) carries one operation per transfer:
//   i_kind, i_position and i_data_word. Every operation yields exactly one
//   result transfer on the output channel (o_valid / i_ready) with the word
//   read or removed, a status code and the list length after the operation.
//   The result is registered at the edge that accepts the operation.
//   Throughput is one operation per cycle while results are taken; the row
//   of cells updates every entry in parallel, so inserts and removes cost
//   no more than a get. The output register sits between the channels,
//   so a new operation is accepted while the receiver takes the last result.
//   When the receiver stalls with a result held, o_ready drops until that
//   result is taken. Reset empties the list (length zero) and drops o_valid;
//   cell contents are not cleared, which is harmless because only entries
//   below the length are ever read.
// ----------------------------------------------------------------------------
module indexed_shift_list_top
    import isl_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [POS_W-1:0]    i_position,
    input  logic [DATA_W-1:0]   i_data_word,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [DATA_W-1:0]   o_read_word,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count_now
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_read_word;
    logic [STATUS_W-1:0]  r_status;
    logic [CNT_W-1:0]     r_fill;
    logic [CNT_W-1:0]     n_fill;

    logic                 w_accept;
    logic [WORD_BITS-1:0] w_store_word;
    logic [WORD_BITS-1:0] w_sel_word;
    logic [DATA_W-1:0]    w_sel_ext;
    logic [CMP_W-1:0]     w_pos_ext;
    logic [CMP_W-1:0]     w_fill_ext;
    logic                 w_in_range;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_do_read;
    logic [STATUS_W-1:0]  w_status;
    logic [1:0]           w_op;
    logic [CNT_W-1:0]     w_target;
    logic [IDX_W-1:0]     w_target_idx;
    t_cell_ctl            w_ctl;

    logic [WORD_BITS-1:0] w_words [CAPACITY];
    logic [WORD_BITS-1:0] w_left  [CAPACITY];
    logic [WORD_BITS-1:0] w_right [CAPACITY];

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // Fit the 32-bit data field to the stored word width and back.
    generate
        if (WORD_BITS > DATA_W) begin : g_wide
            assign w_store_word = {{(WORD_BITS - DATA_W){1'b0}}, i_data_word};
            assign w_sel_ext    = w_sel_word[DATA_W-1:0];
        end else if (WORD_BITS == DATA_W) begin : g_same
            assign w_store_word = i_data_word;
            assign w_sel_ext    = w_sel_word;
        end else begin : g_narrow
            assign w_store_word = i_data_word[WORD_BITS-1:0];
            assign w_sel_ext    = {{(DATA_W - WORD_BITS){1'b0}}, w_sel_word};
        end
    endgenerate

    assign w_pos_ext  = CMP_W'(i_position);
    assign w_fill_ext = CMP_W'(r_fill);
    assign w_in_range = (w_pos_ext < w_fill_ext);
    assign w_full     = (r_fill == CNT_W'(CAPACITY));
    assign w_empty    = (r_fill == '0);

    // Decode the operation into one action for the whole row of cells.
    always_comb begin
        w_op      = CELL_HOLD;
        w_target  = '0;
        w_status  = ST_OK;
        w_do_read = 1'b0;
        n_fill    = r_fill;
        unique case (i_kind)
            KIND_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op     = CELL_LOAD;
                    w_target = r_fill;
                    n_fill   = r_fill + 1'b1;
                end
            end
            KIND_GET: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else begin
                    w_target  = CNT_W'(i_position);
                    w_do_read = 1'b1;
                end
            end
            KIND_PUT: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op     = CELL_LOAD;
                    w_target = CNT_W'(i_position);
                end
            end
            KIND_INSERT: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op     = CELL_INS;
                    w_target = CNT_W'(i_position);
                    n_fill   = r_fill + 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op      = CELL_DEL;
                    w_target  = CNT_W'(i_position);
                    w_do_read = 1'b1;
                    n_fill    = r_fill - 1'b1;
                end
            end
            KIND_POP: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op      = CELL_DEL;
                    w_target  = r_fill - 1'b1;
                    w_do_read = 1'b1;
                    n_fill    = r_fill - 1'b1;
                end
            end
            KIND_SHIFT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op      = CELL_DEL;
                    w_do_read = 1'b1;
                    n_fill    = r_fill - 1'b1;
                end
            end
            default: begin
                w_op = CELL_HOLD;
            end
        endcase
    end

    // Whenever an access is valid, the target is below the capacity.
    assign w_target_idx = w_target[IDX_W-1:0];
    assign w_sel_word   = w_do_read ? w_words[w_target_idx] : '0;

    assign w_ctl.op     = w_accept ? w_op : CELL_HOLD;
    assign w_ctl.target = MAX_IDX_W'(w_target);

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cells
            if (g == 0) begin : g_first
                assign w_left[g] = '0;
            end else begin : g_left
                assign w_left[g] = w_words[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right[g] = '0;
            end else begin : g_right
                assign w_right[g] = w_words[g+1];
            end

            isl_cell #(
                .WORD_BITS  (WORD_BITS),
                .CELL_INDEX (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_load_word  (w_store_word),
                .i_left_word  (w_left[g]),
                .i_right_word (w_right[g]),
                .o_word       (w_words[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_fill      <= n_fill;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_word <= w_sel_ext;
            r_status    <= w_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_word = r_read_word;
    assign o_status    = r_status;
    assign o_count_now = COUNT_W'(r_fill);

endmodule

/* rtl/isl_cell.sv */
// ----------------------------------------------------------------------------
// isl_cell: one storage cell of the indexed shift list
// Holds one list entry and, on each cycle, keeps it, loads the new word,
// or takes the word of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module isl_cell
    import isl_pkg::*;
#(
    parameter int WORD_BITS  = DEF_WORD_BITS,
    parameter int CELL_INDEX = 0
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [WORD_BITS-1:0] i_load_word,
    input  logic [WORD_BITS-1:0] i_left_word,
    input  logic [WORD_BITS-1:0] i_right_word,
    output logic [WORD_BITS-1:0] o_word
);

    localparam logic [MAX_IDX_W-1:0] MY_IDX = MAX_IDX_W'(CELL_INDEX);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 w_hit;
    logic                 w_above;

    assign w_hit   = (MY_IDX == i_ctl.target);
    assign w_above = (MY_IDX > i_ctl.target);

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            CELL_LOAD: begin
                if (w_hit) begin
                    n_word = i_load_word;
                end
            end
            CELL_INS: begin
                if (w_hit) begin
                    n_word = i_load_word;
                end else if (w_above) begin
                    n_word = i_left_word;
                end
            end
            CELL_DEL: begin
                if (w_hit || w_above) begin
                    n_word = i_right_word;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

/* verif/tb_indexed_shift_list_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_shift_list_top: self-checking bench for the indexed shift list
// Drives list operations through the valid/ready input channel with random
// gaps, predicts every result from a shadow copy of the list and compares
// each output transfer field by field while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_indexed_shift_list_top;
    import isl_pkg::*;

    localparam int LIST_DEPTH = DEF_CAPACITY;
    localparam int LIST_WORD_BITS = DEF_WORD_BITS;
    localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - LIST_WORD_BITS);
    // The kind field has one code that the block treats as a no-op.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int MAX_WAIT = 12;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DATA_W-1:0]   word;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_list_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [KIND_W-1:0]   i_kind = '0;
    logic [POS_W-1:0]    i_position = '0;
    logic [DATA_W-1:0]   i_data_word = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [DATA_W-1:0]   o_read_word;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_count_now;

    // Shadow copy of the list, updated at each accepted operation.
    logic [DATA_W-1:0] shadow_words [LIST_DEPTH];
    int                shadow_len = 0;

    t_list_reply expected_replies [$];

    bit rst_done = 1'b0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    int fail_count = 0;
    int ops_sent = 0;
    int replies_checked = 0;
    int peak_len = 0;
    int status_hits [4] = '{0, 0, 0, 0};
    int kind_hits [8] = '{0, 0, 0, 0, 0, 0, 0, 0};

    indexed_shift_list_top #(
        .CAPACITY  (LIST_DEPTH),
        .WORD_BITS (LIST_WORD_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_position  (i_position),
        .i_data_word (i_data_word),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_read_word (o_read_word),
        .o_status    (o_status),
        .o_count_now (o_count_now)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d replies still outstanding", expected_replies.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Removes the word at idx and closes the gap from above.
    function automatic logic [DATA_W-1:0] take_word(input int idx);
        logic [DATA_W-1:0] w;
        int i;
        w = shadow_words[idx];
        for (i = idx; i + 1 < shadow_len; i++) begin
            shadow_words[i] = shadow_words[i + 1];
        end
        shadow_len--;
        return w;
    endfunction

    function automatic t_list_reply apply_list_op(input logic [KIND_W-1:0] kind,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [DATA_W-1:0] data);
        t_list_reply r;
        logic [DATA_W-1:0] w;
        int p;
        int i;
        p = int'(pos);
        w = data & WORD_MASK;
        r.word = '0;
        r.status = ST_OK;
        case (kind)
            KIND_APPEND: begin
                if (shadow_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[shadow_len] = w;
                    shadow_len++;
                end
            end
            KIND_GET: begin
                if (p >= shadow_len) r.status = ST_RANGE;
                else r.word = shadow_words[p];
            end
            KIND_PUT: begin
                if (p >= shadow_len) r.status = ST_RANGE;
                else shadow_words[p] = w;
            end
            KIND_INSERT: begin
                // The index check wins over the full check.
                if (p >= shadow_len) begin
                    r.status = ST_RANGE;
                end else if (shadow_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_len; i > p; i--) begin
                        shadow_words[i] = shadow_words[i - 1];
                    end
                    shadow_words[p] = w;
                    shadow_len++;
                end
            end
            KIND_REMOVE: begin
                if (p >= shadow_len) r.status = ST_RANGE;
                else r.word = take_word(p);
            end
            KIND_POP: begin
                if (shadow_len == 0) r.status = ST_EMPTY;
                else r.word = take_word(shadow_len - 1);
            end
            KIND_SHIFT: begin
                if (shadow_len == 0) r.status = ST_EMPTY;
                else r.word = take_word(0);
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(shadow_len);
        return r;
    endfunction

    // Presents one operation and returns at the edge of its transfer.
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] data);
        int gap;
        t_list_reply r;
        gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_position <= pos;
        i_data_word <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = apply_list_op(kind, pos, data);
        expected_replies.push_back(r);
        ops_sent++;
        kind_hits[kind]++;
        status_hits[r.status]++;
        if (shadow_len > peak_len) peak_len = shadow_len;
    endtask

    // Receiver: random stall before each transfer, then compare with the
    // oldest prediction.
    initial begin
        int stall;
        t_list_reply want;
        while (!rst_done) @(posedge i_clk);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            replies_checked++;
            if (expected_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("%0t: result with nothing outstanding:", $realtime);
                    $display("    word %h status %0d count %0d",
                             o_read_word, o_status, o_count_now);
                end
            end else begin
                want = expected_replies.pop_front();
                if (o_read_word !== want.word || o_status !== want.status ||
                    o_count_now !== want.count) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch: expected word %h status %0d count %0d",
                                 $realtime, want.word, want.status, want.count);
                        $display("    got word %h status %0d count %0d",
                                 o_read_word, o_status, o_count_now);
                    end
                end
            end
        end
    end

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a valid index, sometimes the length itself, sometimes anything.
    function automatic logic [POS_W-1:0] pick_position();
        int p;
        p = $urandom_range(0, 99);
        if (p < 80 && shadow_len > 0) return POS_W'($urandom_range(0, shadow_len - 1));
        if (p < 88 && shadow_len < LIST_DEPTH) return POS_W'(shadow_len);
        return POS_W'($urandom_range(0, LIST_DEPTH - 1));
    endfunction

    task automatic test_empty_list();
        send_op(KIND_GET, 6'd0, 32'h0);
        send_op(KIND_PUT, 6'd63, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 6'd0, 32'h1357_9BDF);
        send_op(KIND_REMOVE, 6'd0, 32'h0);
        send_op(KIND_POP, 6'd0, 32'h0);
        send_op(KIND_SHIFT, 6'd63, 32'h0);
        send_op(KIND_UNUSED, 6'd63, 32'hFFFF_FFFF);
    endtask

    task automatic test_basic_ops();
        send_op(KIND_APPEND, 6'd63, 32'hFFFF_FFFF);
        send_op(KIND_APPEND, 6'd0, 32'h0000_0000);
        send_op(KIND_APPEND, 6'd21, 32'hA5A5_A5A5);
        send_op(KIND_GET, 6'd0, 32'h0);
        send_op(KIND_GET, 6'd2, 32'h0);
        // An index equal to the length is out of range for everything but append.
        send_op(KIND_GET, 6'd3, 32'h0);
        send_op(KIND_PUT, 6'd1, 32'h5A5A_5A5A);
        send_op(KIND_GET, 6'd1, 32'h0);
        send_op(KIND_PUT, 6'd3, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 6'd0, 32'h1234_5678);
        send_op(KIND_INSERT, 6'd3, 32'hDEAD_BEEF);
        send_op(KIND_INSERT, 6'd5, 32'h0BAD_F00D);
        send_op(KIND_REMOVE, 6'd2, 32'h0);
        send_op(KIND_REMOVE, 6'd4, 32'h0);
        send_op(KIND_UNUSED, 6'd1, 32'h0);
        send_op(KIND_POP, 6'd0, 32'h0);
        send_op(KIND_SHIFT, 6'd0, 32'h0);
        send_op(KIND_GET, 6'd63, 32'h0);
    endtask

    task automatic test_full_list();
        while (shadow_len < LIST_DEPTH) begin
            send_op(KIND_APPEND, POS_W'($urandom), pick_word());
        end
        send_op(KIND_APPEND, 6'd0, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 6'd0, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 6'd63, 32'h0);
        send_op(KIND_GET, 6'd63, 32'h0);
        send_op(KIND_PUT, 6'd63, 32'hFFFF_FFFF);
        send_op(KIND_REMOVE, 6'd63, 32'h0);
        send_op(KIND_INSERT, 6'd62, 32'hC0DE_CAFE);
        send_op(KIND_GET, 6'd63, 32'h0);
        while (shadow_len > 0) begin
            case ($urandom_range(0, 2))
                0: send_op(KIND_POP, 6'd0, 32'h0);
                1: send_op(KIND_SHIFT, 6'd0, 32'h0);
                default: send_op(KIND_REMOVE, pick_position(), 32'h0);
            endcase
        end
        send_op(KIND_POP, 6'd0, 32'h0);
        send_op(KIND_SHIFT, 6'd0, 32'h0);
    endtask

    // Random operations in phases that steer the length toward a target,
    // so both the empty and the full list are visited repeatedly.
    task automatic test_random_mix(input int phases, input int per_phase);
        int ph;
        int n;
        int goal;
        int r;
        logic [KIND_W-1:0] kind;
        for (ph = 0; ph < phases; ph++) begin
            case ($urandom_range(0, 4))
                0: goal = 0;
                1: goal = LIST_DEPTH;
                default: goal = $urandom_range(0, LIST_DEPTH);
            endcase
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < per_phase; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    kind = KIND_UNUSED;
                end else if (r < 48) begin
                    if (shadow_len < goal) begin
                        kind = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
                    end else begin
                        case ($urandom_range(0, 2))
                            0: kind = KIND_REMOVE;
                            1: kind = KIND_POP;
                            default: kind = KIND_SHIFT;
                        endcase
                    end
                end else if (r < 66) begin
                    kind = KIND_GET;
                end else if (r < 82) begin
                    kind = KIND_PUT;
                end else begin
                    kind = KIND_W'($urandom_range(0, 7));
                end
                send_op(kind, pick_position(), pick_word());
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_random_mix(20, 50);

        i_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (expected_replies.size() != 0) begin
            fail_count++;
            $display("%0d predicted replies never arrived", expected_replies.size());
        end
        $display("Ran %0d list operations, checked %0d replies, %0d failures; peak length %0d.",
                 ops_sent, replies_checked, fail_count, peak_len);
        $display("Status mix: %0d ok, %0d out of range, %0d full, %0d empty; %0d no-op kinds.",
                 status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_FULL],
                 status_hits[ST_EMPTY], kind_hits[KIND_UNUSED]);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/isl_pkg.sv
rtl/isl_cell.sv
rtl/indexed_shift_list_top.sv
verif/tb_indexed_shift_list_top.sv
